// ----- hw/rtl/url_span_scanner_core_defines.svh -----
// Assertion macros shared by the URL span scanner RTL.
// Needs a clock named clk and an active-low reset named rst_n in the using scope.
`ifndef URL_SPAN_SCANNER_CORE_DEFINES_SVH
`define URL_SPAN_SCANNER_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define USS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("uss assertion failed");

// Next-cycle implication, checked outside reset.
`define USS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("uss assertion failed");

`endif

// ----- hw/rtl/uss_pkg.sv -----
// Package for the URL span scanner: transfer payload types, the default text
// length limit and the byte classifiers. No dependencies.
package uss_pkg;

  localparam longint unsigned USS_MAX_TEXT_LEN = 64'd65536;

  localparam int TEXT_BYTE_W = 8;
  localparam int SPAN_START_W = 16;
  localparam int SPAN_END_W = 17;

  typedef struct packed {
    logic [TEXT_BYTE_W-1:0] text_byte;
    logic                   end_of_text;
  } uss_in_t;

  typedef struct packed {
    logic                    span_found;
    logic [SPAN_START_W-1:0] span_start;
    logic [SPAN_END_W-1:0]   span_end;
  } uss_out_t;

  // Progress through the "://" separator.
  typedef enum logic [1:0] {
    SEP_NONE   = 2'd0,
    SEP_COLON  = 2'd1,
    SEP_SLASH1 = 2'd2,
    SEP_FULL   = 2'd3
  } uss_sep_t;

  localparam logic [7:0] CHAR_COLON = 8'h3A;
  localparam logic [7:0] CHAR_SLASH = 8'h2F;

  function automatic logic uss_is_letter(input logic [7:0] c);
    logic r;
    r = (c inside {[8'h41:8'h5A], [8'h61:8'h7A]});
    return r;
  endfunction

  // Letters, digits and the marks ~;/?:@=&$-_.+!*'(),
  function automatic logic uss_is_url_char(input logic [7:0] c);
    logic r;
    r = (c inside {[8'h41:8'h5A], [8'h61:8'h7A], [8'h30:8'h39],
                   8'h7E, 8'h3B, 8'h2F, 8'h3F, 8'h3A, 8'h40, 8'h3D, 8'h26,
                   8'h24, 8'h2D, 8'h5F, 8'h2E, 8'h2B, 8'h21, 8'h2A, 8'h27,
                   8'h28, 8'h29, 8'h2C});
    return r;
  endfunction

endpackage

// ----- hw/rtl/url_span_scanner_core.sv -----
// URL span scanner top level: input register, span tracking logic and
// result register. Depends on uss_pkg and url_span_scanner_core_defines.svh.
//
// The scanner takes text one byte per transfer and returns exactly one result
// per byte. A URL span is a run of ASCII letters, then "://", then at least
// one URL character (letters, digits and ~;/?:@=&$-_.+!*'(),); the span runs
// until the first byte that is not a URL character, or to the end of the text.
// A result with span_found set reports the span that this byte completed, with
// span_start at its first scheme letter and span_end one past its final URL
// character; otherwise both offsets are zero. A byte marked end_of_text closes
// any open span and puts the offset counter and all tracking state back to
// zero for the next text. Offsets saturate at MAX_TEXT_LEN (starts at
// MAX_TEXT_LEN-1) and are reported in their low 16 and 17 bits. Throughput is
// one byte per clock cycle while the receiver does not stall. A byte's result
// is offered once it moves from the input register into the result register.
// The per-byte state update is combinational logic between those registers:
// the offset increment and compare plus the character classification, which
// sets the clock limit.
`include "url_span_scanner_core_defines.svh"

module url_span_scanner_core
  import uss_pkg::*;
#(
  parameter longint unsigned MAX_TEXT_LEN = USS_MAX_TEXT_LEN
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  uss_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output uss_out_t out_data
);

  // The offset counter holds 0..MAX_TEXT_LEN; start offsets hold 0..MAX_TEXT_LEN-1.
  localparam int OFF_W = $clog2(MAX_TEXT_LEN + 64'd1);
  localparam int POS_W = $clog2(MAX_TEXT_LEN);
  localparam logic [OFF_W:0] MAX_E = (OFF_W+1)'(MAX_TEXT_LEN);
  localparam logic [OFF_W:0] LAST_START_E = MAX_E - 1'b1;
  localparam logic [OFF_W-1:0] MAX_OFF = OFF_W'(MAX_TEXT_LEN);

  // Transfer pipeline registers.
  logic     in_valid_r, in_valid_nxt;
  uss_in_t  in_data_r;
  logic     out_valid_r, out_valid_nxt;
  uss_out_t out_data_r, out_data_nxt;

  // Span tracking state.
  logic [OFF_W-1:0] off_r, off_nxt;
  logic [POS_W-1:0] run_start_r, run_start_nxt;
  logic             run_valid_r, run_valid_nxt;
  uss_sep_t         sep_r, sep_nxt;
  logic [POS_W-1:0] cand_r, cand_nxt;
  logic             inside_r, inside_nxt;
  logic [POS_W-1:0] open_start_r, open_start_nxt;

  logic             in_accept;
  logic             s1_adv;
  logic [7:0]       c;
  logic             last;
  logic             is_url;
  logic             is_let;
  logic [OFF_W:0]   pos_ext;
  logic [OFF_W:0]   pos_p1;
  logic [OFF_W:0]   end_here;
  logic [OFF_W:0]   end_after;
  logic [POS_W-1:0] start_here;
  logic             found;
  logic [POS_W-1:0] found_start;
  logic [OFF_W:0]   found_end;

  // The held byte moves into the result register whenever that register is
  // empty or its result is being taken in this cycle.
  assign s1_adv    = in_valid_r && (!out_valid_r || !out_stall);
  assign in_stall  = in_valid_r && !s1_adv;
  assign in_accept = in_valid && !in_stall;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    in_valid_nxt = in_valid_r;
    if (in_accept) begin
      in_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      in_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (s1_adv) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Offsets of the current byte, saturated at the text length limit.
  assign c          = in_data_r.text_byte;
  assign last       = in_data_r.end_of_text;
  assign is_url     = uss_is_url_char(c);
  assign is_let     = uss_is_letter(c);
  assign pos_ext    = {1'b0, off_r};
  assign pos_p1     = pos_ext + 1'b1;
  assign end_here   = pos_ext;
  assign end_after  = (pos_p1 > MAX_E) ? MAX_E : pos_p1;
  assign start_here = (pos_ext < LAST_START_E) ? POS_W'(pos_ext) : POS_W'(LAST_START_E);

  always_comb begin
    run_start_nxt  = run_start_r;
    run_valid_nxt  = run_valid_r;
    sep_nxt        = sep_r;
    cand_nxt       = cand_r;
    inside_nxt     = inside_r;
    open_start_nxt = open_start_r;
    found          = 1'b0;
    found_start    = '0;
    found_end      = '0;
    off_nxt        = off_r;

    if (inside_r) begin
      // An open span goes on over URL characters and closes on anything else.
      if (is_url) begin
        if (last) begin
          found       = 1'b1;
          found_start = open_start_r;
          found_end   = end_after;
        end
      end else begin
        found       = 1'b1;
        found_start = open_start_r;
        found_end   = end_here;
        inside_nxt  = 1'b0;
      end
      run_valid_nxt = 1'b0;
      sep_nxt       = SEP_NONE;
    end else if (sep_r == SEP_FULL && is_url) begin
      // First URL character after the separator opens the span.
      inside_nxt     = 1'b1;
      open_start_nxt = cand_r;
      run_valid_nxt  = 1'b0;
      sep_nxt        = SEP_NONE;
      if (last) begin
        found       = 1'b1;
        found_start = cand_r;
        found_end   = end_after;
        inside_nxt  = 1'b0;
      end
    end else if (c == CHAR_COLON) begin
      if (run_valid_r) begin
        cand_nxt = run_start_r;
        sep_nxt  = SEP_COLON;
      end else begin
        sep_nxt = SEP_NONE;
      end
      run_valid_nxt = 1'b0;
    end else if (c == CHAR_SLASH) begin
      case (sep_r)
        SEP_COLON:  sep_nxt = SEP_SLASH1;
        SEP_SLASH1: sep_nxt = SEP_FULL;
        default:    sep_nxt = SEP_NONE;
      endcase
      run_valid_nxt = 1'b0;
    end else if (is_let) begin
      if (!run_valid_r) begin
        run_start_nxt = start_here;
        run_valid_nxt = 1'b1;
      end
      sep_nxt = SEP_NONE;
    end else begin
      run_valid_nxt = 1'b0;
      sep_nxt       = SEP_NONE;
    end

    // The final byte of a text clears everything for the next one.
    if (last) begin
      off_nxt        = '0;
      run_start_nxt  = '0;
      run_valid_nxt  = 1'b0;
      sep_nxt        = SEP_NONE;
      cand_nxt       = '0;
      inside_nxt     = 1'b0;
      open_start_nxt = '0;
    end else if (off_r != MAX_OFF) begin
      off_nxt = off_r + 1'b1;
    end

    out_data_nxt.span_found = found;
    out_data_nxt.span_start = SPAN_START_W'(found_start);
    out_data_nxt.span_end   = SPAN_END_W'(found_end);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
      off_r        <= '0;
      run_start_r  <= '0;
      run_valid_r  <= 1'b0;
      sep_r        <= SEP_NONE;
      cand_r       <= '0;
      inside_r     <= 1'b0;
      open_start_r <= '0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (s1_adv) begin
        off_r        <= off_nxt;
        run_start_r  <= run_start_nxt;
        run_valid_r  <= run_valid_nxt;
        sep_r        <= sep_nxt;
        cand_r       <= cand_nxt;
        inside_r     <= inside_nxt;
        open_start_r <= open_start_nxt;
      end
    end
  end

  // Payload registers load without reset.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      in_data_r <= in_data;
    end
    if (s1_adv) begin
      out_data_r <= out_data_nxt;
    end
  end

  // A pending separator and an open span never coexist.
  `USS_ASSERT_NOW(a_sep_vs_span, inside_r, sep_r == SEP_NONE)
  // A letter run is never tracked while a span is open.
  `USS_ASSERT_NOW(a_run_vs_span, inside_r, !run_valid_r)
  // Results that report no span carry zero offsets.
  `USS_ASSERT_NOW(a_empty_result, out_valid_r && !out_data_r.span_found,
                  out_data_r.span_start == '0 && out_data_r.span_end == '0)
  // The end-of-text byte returns the offset counter and span state to zero.
  `USS_ASSERT_NEXT(a_text_restart, s1_adv && in_data_r.end_of_text,
                   off_r == '0 && !inside_r)

endmodule

// ----- bench/url_span_scanner_checker.sv -----
// Checker for the URL span scanner: watches both transfer channels, predicts the result of
// every accepted byte and compares it with what the scanner returns. Depends on uss_pkg.
module url_span_scanner_checker
  import uss_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     in_stall,
  input  uss_in_t  in_data,
  input  logic     out_valid,
  input  logic     out_stall,
  input  uss_out_t out_data,
  output int       fail_count,
  output int       pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint unsigned TEXT_LIMIT = USS_MAX_TEXT_LEN;

  // Scanner state as the predictor keeps it.
  longint unsigned byte_pos;
  longint unsigned run_start;
  bit              run_live;
  uss_sep_t        sep;
  longint unsigned cand_start;
  bit              span_open;
  longint unsigned span_open_start;

  uss_out_t expected_spans[$];

  initial begin
    fail_count = 0;
    pending = 0;
  end

  function automatic bit is_alpha(logic [7:0] c);
    return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
  endfunction

  function automatic bit is_link_byte(logic [7:0] c);
    if (is_alpha(c) || (c >= "0" && c <= "9")) begin
      return 1'b1;
    end
    case (c)
      "~", ";", "/", "?", ":", "@", "=", "&", "$", "-", "_", ".", "+", "!", "*", "'",
      "(", ")", ",": return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic longint unsigned end_cap(longint unsigned p);
    return (p < TEXT_LIMIT) ? p : TEXT_LIMIT;
  endfunction

  task automatic clear_scan();
    byte_pos = 0;
    run_start = 0;
    run_live = 1'b0;
    sep = SEP_NONE;
    cand_start = 0;
    span_open = 1'b0;
    span_open_start = 0;
  endtask

  // Advances the predicted scanner by one byte and returns the result it owes.
  task automatic scan_byte(input uss_in_t item, output uss_out_t res);
    logic [7:0]      c;
    bit              link;
    bit              found;
    bit              last;
    longint unsigned pos;
    longint unsigned s_start;
    longint unsigned s_end;
    c = item.text_byte;
    last = item.end_of_text;
    link = is_link_byte(c);
    found = 1'b0;
    s_start = 0;
    s_end = 0;
    pos = byte_pos;
    if (span_open) begin
      if (link) begin
        if (last) begin
          found = 1'b1;
          s_start = span_open_start;
          s_end = end_cap(pos + 1);
        end
      end else begin
        found = 1'b1;
        s_start = span_open_start;
        s_end = end_cap(pos);
        span_open = 1'b0;
      end
      run_live = 1'b0;
      sep = SEP_NONE;
    end else if (sep == SEP_FULL && link) begin
      span_open = 1'b1;
      span_open_start = cand_start;
      run_live = 1'b0;
      sep = SEP_NONE;
      if (last) begin
        found = 1'b1;
        s_start = span_open_start;
        s_end = end_cap(pos + 1);
        span_open = 1'b0;
      end
    end else if (c == CHAR_COLON) begin
      if (run_live) begin
        cand_start = run_start;
        sep = SEP_COLON;
      end else begin
        sep = SEP_NONE;
      end
      run_live = 1'b0;
    end else if (c == CHAR_SLASH) begin
      if (sep == SEP_COLON) begin
        sep = SEP_SLASH1;
      end else if (sep == SEP_SLASH1) begin
        sep = SEP_FULL;
      end else begin
        sep = SEP_NONE;
      end
      run_live = 1'b0;
    end else if (is_alpha(c)) begin
      if (!run_live) begin
        run_start = (pos < TEXT_LIMIT - 1) ? pos : TEXT_LIMIT - 1;
        run_live = 1'b1;
      end
      sep = SEP_NONE;
    end else begin
      run_live = 1'b0;
      sep = SEP_NONE;
    end
    if (last) begin
      clear_scan();
    end else if (byte_pos < TEXT_LIMIT) begin
      byte_pos++;
    end
    res.span_found = found;
    res.span_start = s_start[SPAN_START_W-1:0];
    res.span_end = s_end[SPAN_END_W-1:0];
  endtask

  task automatic note_mismatch(string field, longint unsigned want, longint unsigned got);
    fail_count++;
    $error("%s mismatch: expected %0d, actual %0d", field, want, got);
  endtask

  always @(posedge clk) begin : watch
    uss_out_t want;
    if (!rst_n) begin
      clear_scan();
      expected_spans.delete();
    end else begin
      if (in_valid && !in_stall) begin
        scan_byte(in_data, want);
        expected_spans.insert(expected_spans.size(), want);
      end
      if (out_valid && !out_stall) begin
        if (expected_spans.size() == 0) begin
          fail_count++;
          $error("result transfer with no byte outstanding");
        end else begin
          want = expected_spans.pop_front();
          if (out_data.span_found !== want.span_found) begin
            note_mismatch("span_found", 64'(want.span_found), 64'(out_data.span_found));
          end
          if (out_data.span_start !== want.span_start) begin
            note_mismatch("span_start", 64'(want.span_start), 64'(out_data.span_start));
          end
          if (out_data.span_end !== want.span_end) begin
            note_mismatch("span_end", 64'(want.span_end), 64'(out_data.span_end));
          end
        end
      end
    end
    pending = expected_spans.size();
  end

endmodule

// ----- bench/url_span_scanner_core_test.sv -----
// Top of the URL span scanner testbench: clock, reset, byte stimulus, receiver stalls and
// the verdict. Depends on uss_pkg, url_span_scanner_core and url_span_scanner_checker.
module url_span_scanner_core_test
  import uss_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  logic     clk = 1'b0;
  logic     rst_n;
  logic     in_valid;
  logic     in_stall;
  uss_in_t  in_data;
  logic     out_valid;
  logic     out_stall = 1'b0;
  uss_out_t out_data;
  int       fail_count;
  int       pending;

  // Percentages of cycles in which the sender holds back a byte and the receiver stalls.
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  // Number of byte transfers completed so far.
  int sent = 0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  url_span_scanner_core i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  url_span_scanner_checker i_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .fail_count(fail_count),
    .pending   (pending)
  );

  // The receiver decides afresh at every falling edge whether to stall, so stalls land on
  // every phase of the scanner's two-stage pipeline.
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // Offers one byte and returns at the falling edge after its transfer. Idle cycles are
  // inserted before the byte is offered; once valid is raised the payload holds until the
  // scanner stops stalling. The stall is read right after the rising edge, so it is the
  // value that decided the transfer at that edge.
  task automatic send_byte(input logic [7:0] b, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{text_byte: b, end_of_text: last};
    do begin
      @(posedge clk);
    end while (in_stall);
    sent++;
    @(negedge clk);
  endtask

  // Sends a string; only its final byte may carry the end-of-text mark.
  task automatic send_string(input string s, input logic last);
    for (int k = 0; k < s.len(); k++) begin
      send_byte(s[k], last && (k == s.len() - 1));
    end
  endtask

  function automatic logic [7:0] pick_letter();
    int r;
    r = $urandom_range(51);
    return (r < 26) ? 8'(8'h41 + r) : 8'(8'h61 + r - 26);
  endfunction

  // A byte that may follow the separator and extend a span.
  function automatic logic [7:0] pick_link();
    string marks;
    marks = "~;/?:@=&$-_.+!*'(),";
    case ($urandom_range(2))
      0: return pick_letter();
      1: return 8'(8'h30 + $urandom_range(9));
      default: return marks[$urandom_range(marks.len() - 1)];
    endcase
  endfunction

  // A byte that closes a span: control codes, space, the high half and most of the printable
  // characters outside the URL set.
  function automatic logic [7:0] pick_stop();
    string others;
    others = "\"#%<>[\\]^{|}";
    case ($urandom_range(3))
      0: return 8'($urandom_range(32));
      1: return 8'($urandom_range(255, 127));
      2: return others[$urandom_range(others.len() - 1)];
      default: return 8'h20;
    endcase
  endfunction

  // One chunk of random text. Most chunks are well-formed scheme/separator/body sequences
  // so the scanner keeps reaching an open span; the rest break the separator, leave out the
  // scheme letters, or are plain noise over the full byte range. Any byte may end the text.
  task automatic send_segment();
    logic [7:0] seg[$];
    int         kind;
    int         n;
    kind = $urandom_range(9);
    if (kind <= 6) begin
      n = $urandom_range(5, 1);
      repeat (n) seg.insert(seg.size(), pick_letter());
      seg.insert(seg.size(), CHAR_COLON);
      seg.insert(seg.size(), CHAR_SLASH);
      seg.insert(seg.size(), CHAR_SLASH);
      // Now and then the separator is followed directly by a stop byte.
      n = ($urandom_range(7) == 0) ? 0 : $urandom_range(10, 1);
      repeat (n) seg.insert(seg.size(), pick_link());
      if ($urandom_range(3) != 0) begin
        seg.insert(seg.size(), pick_stop());
      end
    end else if (kind == 7) begin
      // Letters and a separator cut short by an arbitrary byte.
      n = $urandom_range(4, 1);
      repeat (n) seg.insert(seg.size(), pick_letter());
      seg.insert(seg.size(), CHAR_COLON);
      if ($urandom_range(1)) begin
        seg.insert(seg.size(), CHAR_SLASH);
      end
      seg.insert(seg.size(), 8'($urandom_range(255)));
    end else if (kind == 8) begin
      // A full separator with no letter in front of it.
      seg.insert(seg.size(), pick_stop());
      seg.insert(seg.size(), CHAR_COLON);
      seg.insert(seg.size(), CHAR_SLASH);
      seg.insert(seg.size(), CHAR_SLASH);
      n = $urandom_range(4, 1);
      repeat (n) seg.insert(seg.size(), pick_link());
    end else begin
      n = $urandom_range(8, 1);
      repeat (n) seg.insert(seg.size(), 8'($urandom_range(255)));
    end
    foreach (seg[k]) begin
      send_byte(seg[k], $urandom_range(39) == 0);
    end
  endtask

  task automatic run_phase(input int idle_pct, input int stall_pct, input int count);
    int target;
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    target = sent + count;
    while (sent < target) begin
      send_segment();
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    send_idle_pct = 20;
    recv_stall_pct = 53;

    // A span that holds a second separator and is still open when the text ends on a
    // byte outside the URL set (the zero byte).
    send_string("a://b://", 1'b0);
    send_byte(8'h00, 1'b1);
    // A separator with no letters before it, one followed by a space, and a separator
    // still pending when the text ends.
    send_string("://q:// z://", 1'b1);
    // The top byte value, then a span closed by the end-of-text mark on a URL character.
    send_byte(8'hFF, 1'b0);
    send_string("A://Z", 1'b1);

    run_phase(20, 53, 370);
    run_phase(53, 20, 380);
    run_phase(0, 0, 380);
    in_valid <= 1'b0;

    // Let the outstanding results drain, then allow for the pipeline depth.
    for (int n = 0; n < 20000 && pending != 0; n++) begin
      @(negedge clk);
    end
    repeat (8) @(negedge clk);

    if (fail_count == 0 && pending == 0) begin
      $display("url_span_scanner_core_test passed");
    end else begin
      $display("url_span_scanner_core_test failed");
    end
    $finish;
  end

  // Watchdog: the full run takes well under a tenth of this.
  initial begin
    #60_000_000;
    $display("url_span_scanner_core_test failed");
    $finish;
  end

endmodule
